[hdl/pse_pkg.sv]
// Shared types, constants and byte helpers for the stored-deflate PNG encoder.
package pse_pkg;

  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic        start;
    logic        filter;
    logic        last;
    logic [7:0]  data;
    logic [13:0] w;
    logic [13:0] h;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0: r = w[31:24];
      2'd1: r = w[23:16];
      2'd2: r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

  // fixed bytes of signature, IHDR and IDAT header
  function automatic logic [7:0] hdr_byte(input logic [5:0] idx);
    logic [7:0] r;
    case (idx)
      6'd0: r = 8'h89;
      6'd1: r = 8'h50;
      6'd2: r = 8'h4E;
      6'd3: r = 8'h47;
      6'd4: r = 8'h0D;
      6'd5: r = 8'h0A;
      6'd6: r = 8'h1A;
      6'd7: r = 8'h0A;
      6'd11: r = 8'd13;
      6'd12: r = 8'h49;
      6'd13: r = 8'h48;
      6'd14: r = 8'h44;
      6'd15: r = 8'h52;
      6'd24: r = 8'd8;
      6'd25: r = 8'd6;
      6'd37: r = 8'h49;
      6'd38: r = 8'h44;
      6'd39: r = 8'h41;
      6'd40: r = 8'h54;
      6'd41: r = 8'h78;
      6'd42: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trl_byte(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd12: r = 8'h49;
      5'd13: r = 8'h45;
      5'd14: r = 8'h4E;
      5'd15: r = 8'h44;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[hdl/png_stored_deflate_encoder.sv]
// Top level: RGBA8 byte stream in, PNG file with stored deflate blocks out.
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//  in        in         in_valid/in_stall      pixel_byte
//  out       out        out_valid/out_stall    out_byte, last_of_run, file_end
// A single byte-wide sequencer emits each pixel byte, after a zero filter
// byte on the first byte of a row, plus 43 bytes of file header, five per
// stored block and 20 of trailer. A two-word queue decouples input
// from the sequencer; out_stall holds the output register and the sequencer.
// Synchronous reset.
module png_stored_deflate_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        file_end
);

  pse_pkg::entry_t push_data;
  pse_pkg::entry_t pop_data;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  pse_front u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .pixel_byte, .q_full, .push, .push_data
  );

  pse_fifo u_fifo (
    .clk, .rst, .push, .push_data, .full(q_full), .pop, .pop_data, .empty(q_empty)
  );

  pse_back u_back (
    .clk, .rst, .q_empty, .pop, .pop_data, .out_valid, .out_stall,
    .out_byte, .last_of_run, .file_end
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && file_end |-> last_of_run)
    else $error("file end without end of run");

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output word right after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue read while empty");

endmodule

[hdl/pse_front.sv]
// Front end: configuration registers, row tracking and word classification.
module pse_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          pixel_byte,
  input  logic                q_full,
  output logic                push,
  output pse_pkg::entry_t     push_data
);

  logic [13:0] image_width;
  logic [13:0] image_height;
  logic        file_started;
  logic [15:0] row_byte_count;
  logic [13:0] row_count;
  logic [13:0] fw;
  logic [13:0] fh;
  logic [13:0] w_eff;
  logic [13:0] h_eff;
  logic [15:0] rb_next;
  logic        row_end;
  logic        last;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  always_comb begin
    if (file_started) begin
      w_eff = fw;
      h_eff = fh;
    end else begin
      w_eff = (image_width == 14'd0) ? 14'd1 : image_width;
      h_eff = (image_height == 14'd0) ? 14'd1 : image_height;
    end
    rb_next = row_byte_count + 16'd1;
    row_end = (rb_next == {w_eff, 2'b00});
    last    = row_end && (row_count == h_eff - 14'd1);
    push_data.start  = !file_started;
    push_data.filter = (row_byte_count == 16'd0);
    push_data.last   = last;
    push_data.data   = pixel_byte;
    push_data.w      = w_eff;
    push_data.h      = h_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 14'd1;
      image_height   <= 14'd1;
      file_started   <= 1'b0;
      row_byte_count <= 16'd0;
      row_count      <= 14'd0;
      fw             <= 14'd1;
      fh             <= 14'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pse_pkg::REG_WIDTH) image_width <= cfg_data[13:0];
        else if (cfg_index == pse_pkg::REG_HEIGHT) image_height <= cfg_data[13:0];
      end
      if (push) begin
        fw <= w_eff;
        fh <= h_eff;
        if (last) begin
          file_started   <= 1'b0;
          row_byte_count <= 16'd0;
          row_count      <= 14'd0;
        end else begin
          file_started <= 1'b1;
          if (row_end) begin
            row_byte_count <= 16'd0;
            row_count      <= row_count + 14'd1;
          end else begin
            row_byte_count <= rb_next;
          end
        end
      end
    end
  end

endmodule

[hdl/pse_fifo.sv]
// Two-word queue between front end and byte sequencer.
module pse_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pse_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output pse_pkg::entry_t pop_data,
  output logic            empty
);

  pse_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

[hdl/pse_back.sv]
// Byte sequencer: headers, stored block framing, checksums and output register.
module pse_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  output logic            pop,
  input  pse_pkg::entry_t pop_data,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            file_end
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_BLKH = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_TRL  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  idx;
  logic [13:0] fw;
  logic [13:0] fh;
  logic        filt;
  logic        last;
  logic [7:0]  pix;
  logic [31:0] crc;
  logic [15:0] adler_a;
  logic [15:0] adler_b;
  logic [15:0] block_left;
  logic [29:0] raw_left;
  logic [29:0] raw;
  logic [14:0] quot;
  logic [14:0] blocks;
  logic [31:0] idat_len;

  logic        adv;
  logic        emit;
  logic        cov;
  logic [7:0]  byte_d;
  logic        lor_d;
  logic        fe_d;
  logic        done;
  logic [15:0] n;
  logic [15:0] inv;
  logic        final_blk;
  logic [16:0] sa;
  logic [16:0] sb;
  logic [15:0] a_next;
  logic [15:0] b_next;
  logic [30:0] qsum;

  assign adv = !out_valid || !out_stall;
  assign pop = !q_empty && ((state == S_IDLE) || (adv && done));

  always_comb begin
    n         = (raw_left < 30'(pse_pkg::BLOCK_MAX)) ? raw_left[15:0] : pse_pkg::BLOCK_MAX;
    inv       = ~n;
    final_blk = (raw_left <= 30'(pse_pkg::BLOCK_MAX));
    qsum      = {1'b0, raw} + 31'(raw[29:16]) + 31'd1;
    emit   = 1'b0;
    cov    = 1'b0;
    byte_d = 8'd0;
    lor_d  = 1'b0;
    fe_d   = 1'b0;
    done   = 1'b0;
    case (state)
      S_HDR: begin
        emit = 1'b1;
        cov  = (idx >= 6'd12 && idx <= 6'd28) || (idx >= 6'd37);
        if (idx >= 6'd16 && idx <= 6'd19) byte_d = pse_pkg::word_byte({18'd0, fw}, idx[1:0]);
        else if (idx >= 6'd20 && idx <= 6'd23)
          byte_d = pse_pkg::word_byte({18'd0, fh}, idx[1:0]);
        else if (idx >= 6'd29 && idx <= 6'd32)
          byte_d = pse_pkg::word_byte(~crc, 2'(idx - 6'd29));
        else if (idx >= 6'd33 && idx <= 6'd36)
          byte_d = pse_pkg::word_byte(idat_len, 2'(idx - 6'd33));
        else byte_d = pse_pkg::hdr_byte(idx);
      end
      S_BLKH: begin
        emit = 1'b1;
        cov  = 1'b1;
        case (idx[2:0])
          3'd0: byte_d = {7'd0, final_blk};
          3'd1: byte_d = n[7:0];
          3'd2: byte_d = n[15:8];
          3'd3: byte_d = inv[7:0];
          default: byte_d = inv[15:8];
        endcase
      end
      S_DATA: begin
        if (block_left != 16'd0) begin
          emit   = 1'b1;
          cov    = 1'b1;
          byte_d = filt ? 8'd0 : pix;
          lor_d  = !filt && !last;
          done   = !filt && !last;
        end
      end
      S_TRL: begin
        emit = 1'b1;
        cov  = (idx <= 6'd3) || (idx >= 6'd12 && idx <= 6'd15);
        if (idx <= 6'd3) byte_d = pse_pkg::word_byte({adler_b, adler_a}, idx[1:0]);
        else if (idx <= 6'd7 || idx >= 6'd16) byte_d = pse_pkg::word_byte(~crc, idx[1:0]);
        else byte_d = pse_pkg::trl_byte(idx[4:0]);
        lor_d = (idx == 6'd19);
        fe_d  = (idx == 6'd19);
        done  = (idx == 6'd19);
      end
      default: ;
    endcase
    sa     = {1'b0, adler_a} + {9'd0, byte_d};
    a_next = (sa >= pse_pkg::ADLER_MOD) ? 16'(sa - pse_pkg::ADLER_MOD) : sa[15:0];
    sb     = {1'b0, adler_b} + {1'b0, a_next};
    b_next = (sb >= pse_pkg::ADLER_MOD) ? 16'(sb - pse_pkg::ADLER_MOD) : sb[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte    <= byte_d;
      last_of_run <= lor_d;
      file_end    <= fe_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= 6'd0;
      out_valid  <= 1'b0;
      crc        <= pse_pkg::CRC_INIT;
      adler_a    <= 16'd1;
      adler_b    <= 16'd0;
      block_left <= 16'd0;
      raw_left   <= 30'd0;
    end else begin
      if (adv) out_valid <= emit;
      if (adv && emit && cov) crc <= pse_pkg::crc_byte(crc, byte_d);
      if (state == S_DATA && block_left == 16'd0) begin
        state <= S_BLKH;
        idx   <= 6'd0;
      end else if (adv) begin
        case (state)
          S_HDR: begin
            idx <= idx + 6'd1;
            case (idx)
              6'd0: begin
                raw        <= fh * {fw, 2'b01};
                block_left <= 16'd0;
                adler_a    <= 16'd1;
                adler_b    <= 16'd0;
                crc        <= pse_pkg::CRC_INIT;
              end
              6'd1: begin
                quot     <= qsum[30:16];
                raw_left <= raw;
              end
              6'd2: blocks <= quot + 15'(raw != (({quot, 16'd0}) - {16'd0, quot}) >> 0);
              6'd3: idat_len <= {2'd0, raw} + 32'd6 + {15'd0, blocks, 2'd0} + {17'd0, blocks};
              6'd32: crc <= pse_pkg::CRC_INIT;
              6'd42: state <= S_DATA;
              default: ;
            endcase
          end
          S_BLKH: begin
            if (idx == 6'd4) begin
              block_left <= n;
              state      <= S_DATA;
            end else begin
              idx <= idx + 6'd1;
            end
          end
          S_DATA: begin
            adler_a    <= a_next;
            adler_b    <= b_next;
            block_left <= block_left - 16'd1;
            raw_left   <= raw_left - 30'd1;
            if (filt) filt <= 1'b0;
            else if (last) begin
              state <= S_TRL;
              idx   <= 6'd0;
            end else state <= S_IDLE;
          end
          S_TRL: begin
            idx <= idx + 6'd1;
            if (idx == 6'd7) crc <= pse_pkg::CRC_INIT;
            if (idx == 6'd19) begin
              crc        <= pse_pkg::CRC_INIT;
              adler_a    <= 16'd1;
              adler_b    <= 16'd0;
              block_left <= 16'd0;
              state      <= S_IDLE;
            end
          end
          default: ;
        endcase
      end
      if (pop) begin
        idx   <= 6'd0;
        filt  <= pop_data.filter;
        last  <= pop_data.last;
        pix   <= pop_data.data;
        state <= pop_data.start ? S_HDR : S_DATA;
        if (pop_data.start) begin
          fw <= pop_data.w;
          fh <= pop_data.h;
        end
      end
    end
  end

endmodule

[verif/tb_png_stored_deflate_encoder.sv]
// Testbench for the stored-deflate PNG encoder: predicts the PNG stream byte by byte and checks.
module tb_png_stored_deflate_encoder;

  localparam int LIMIT = 200000;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       fend;
  } png_word_t;

  typedef struct {
    logic [1:0]  idx;
    logic [15:0] val;
  } reg_write_t;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_stall;
  logic [7:0]  pixel_byte;
  logic        out_valid, out_stall;
  logic [7:0]  out_byte;
  logic        last_of_run, file_end;

  png_word_t  png_q[$];
  logic [7:0] pixel_q[$];
  reg_write_t reg_q[$];

  int  send_idle_pct, recv_idle_pct, cycle_cnt;
  bit  hold_on;
  bit  failed;

  // encoder model state
  logic [13:0] reg_w, reg_h;
  logic [31:0] frame_w, frame_h;
  bit          in_file;
  logic [31:0] row_bytes, blk_left, raw_left;
  logic [31:0] crc, sum_a, sum_b;

  png_stored_deflate_encoder dut (.*);

  function automatic void put_byte(logic [31:0] v, bit covered);
    png_word_t w;
    if (covered) begin
      crc = crc ^ {24'd0, v[7:0]};
      for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 32'hEDB88320) : (crc >> 1);
    end
    w.data = v[7:0];
    w.last = 1'b0;
    w.fend = 1'b0;
    png_q.insert(png_q.size(), w);
  endfunction

  function automatic void put_word(logic [31:0] v, bit covered);
    for (int k = 3; k >= 0; k--) put_byte(v >> (8 * k), covered);
  endfunction

  function automatic void put_crc();
    put_word(crc ^ 32'hFFFFFFFF, 0);
    crc = 32'hFFFFFFFF;
  endfunction

  function automatic void put_raw(logic [7:0] b);
    logic [31:0] n;
    if (raw_left == 0) return;
    if (blk_left == 0) begin
      n = (raw_left < 65535) ? raw_left : 65535;
      put_byte((n == raw_left) ? 1 : 0, 1);
      put_byte(n, 1);
      put_byte(n >> 8, 1);
      put_byte(~n, 1);
      put_byte(~n >> 8, 1);
      blk_left = n;
    end
    put_byte(b, 1);
    sum_a = (sum_a + b) % 65521;
    sum_b = (sum_b + sum_a) % 65521;
    blk_left--;
    raw_left--;
  endfunction

  function automatic void encode_pixel(logic [7:0] b);
    longint unsigned raw, blocks, len;
    if (!in_file) begin
      frame_w = (reg_w == 0) ? 1 : reg_w;
      frame_h = (reg_h == 0) ? 1 : reg_h;
      raw = longint'(frame_h) * (4 * longint'(frame_w) + 1);
      blocks = (raw + 65534) / 65535;
      len = 2 + 5 * blocks + raw + 4;
      put_word(32'h89504E47, 0);
      put_word(32'h0D0A1A0A, 0);
      crc = 32'hFFFFFFFF;
      put_word(13, 0);
      put_word(32'h49484452, 1);
      put_word(frame_w, 1);
      put_word(frame_h, 1);
      put_byte(8, 1);
      put_byte(6, 1);
      put_byte(0, 1);
      put_byte(0, 1);
      put_byte(0, 1);
      put_crc();
      put_word(len[31:0], 0);
      put_word(32'h49444154, 1);
      put_byte(8'h78, 1);
      put_byte(8'h01, 1);
      raw_left = {2'b00, raw[29:0]};
      blk_left = 0;
      row_bytes = 0;
      sum_a = 1;
      sum_b = 0;
      in_file = 1;
    end
    if (row_bytes == 0) put_raw(8'h00);
    put_raw(b);
    row_bytes++;
    if (row_bytes >= 4 * frame_w) row_bytes = 0;
    if (raw_left == 0) begin
      put_word({sum_b[15:0], sum_a[15:0]}, 1);
      put_crc();
      put_word(0, 0);
      put_word(32'h49454E44, 1);
      put_crc();
      png_q[$].fend = 1'b1;
      in_file = 0;
      row_bytes = 0;
      blk_left = 0;
      sum_a = 1;
      sum_b = 0;
    end
    png_q[$].last = 1'b1;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pse_pkg::REG_WIDTH) reg_w = cfg_data[13:0];
        else if (cfg_index == pse_pkg::REG_HEIGHT) reg_h = cfg_data[13:0];
        void'(reg_q.pop_front());
      end
      if (reg_q.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= reg_q[0].idx;
        cfg_data  <= reg_q[0].val;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) encode_pixel(pixel_byte);
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        pixel_byte <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    png_word_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (png_q.size() == 0) begin
          $error("unexpected word: out_byte %h", out_byte);
          failed = 1;
        end else begin
          e = png_q.pop_front();
          if (out_byte !== e.data) begin
            $error("out_byte exp %h got %h", e.data, out_byte);
            failed = 1;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run exp %b got %b", e.last, last_of_run);
            failed = 1;
          end
          if (file_end !== e.fend) begin
            $error("file_end exp %b got %b", e.fend, file_end);
            failed = 1;
          end
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    reg_write_t r;
    r.idx = idx;
    r.val = val;
    reg_q.insert(reg_q.size(), r);
  endtask

  task automatic settle();
    wait (reg_q.size() == 0 && pixel_q.size() == 0 && png_q.size() == 0 && !in_valid);
    repeat (30) @(posedge clk);
  endtask

  task automatic queue_file(int w, int h);
    int wn, hn;
    wn = (w == 0) ? 1 : w;
    hn = (h == 0) ? 1 : h;
    for (int i = 0; i < 4 * wn * hn; i++) pixel_q.insert(pixel_q.size(), 8'($urandom_range(255)));
  endtask

  task automatic run_file(int w, int h);
    write_reg(pse_pkg::REG_WIDTH, 16'(w));
    write_reg(pse_pkg::REG_HEIGHT, 16'(h));
    settle();
    queue_file(w, h);
    settle();
  endtask

  initial begin
    int sent, w, h;
    rst = 1;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    pixel_byte = 0;
    out_stall = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_on = 0;
    cycle_cnt = 0;
    failed = 0;
    reg_w = 1;
    reg_h = 1;
    in_file = 0;
    row_bytes = 0;
    blk_left = 0;
    raw_left = 0;
    crc = 32'hFFFFFFFF;
    sum_a = 1;
    sum_b = 0;
    frame_w = 0;
    frame_h = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // default 1x1 frame, byte extremes
    pixel_q.insert(pixel_q.size(), 8'h00);
    pixel_q.insert(pixel_q.size(), 8'hFF);
    pixel_q.insert(pixel_q.size(), 8'hA5);
    pixel_q.insert(pixel_q.size(), 8'h5A);
    settle();
    // zero size reads as 1; unused indexes ignored; upper data bits masked
    write_reg(pse_pkg::REG_WIDTH, 0);
    write_reg(pse_pkg::REG_HEIGHT, 0);
    write_reg(2'd2, 16'hFFFF);
    write_reg(2'd3, 16'h5A5A);
    settle();
    queue_file(0, 0);
    settle();
    write_reg(pse_pkg::REG_WIDTH, 16'hC002);
    write_reg(pse_pkg::REG_HEIGHT, 16'hC001);
    settle();
    queue_file(2, 1);
    settle();
    run_file(2, 1);

    // latched size: write mid-file, takes effect next file
    write_reg(pse_pkg::REG_WIDTH, 3);
    write_reg(pse_pkg::REG_HEIGHT, 2);
    settle();
    for (int i = 0; i < 8; i++) pixel_q.insert(pixel_q.size(), 8'($urandom_range(255)));
    settle();
    write_reg(pse_pkg::REG_WIDTH, 1);
    settle();
    for (int i = 0; i < 16; i++) pixel_q.insert(pixel_q.size(), 8'($urandom_range(255)));
    settle();
    write_reg(pse_pkg::REG_WIDTH, 1);
    write_reg(pse_pkg::REG_HEIGHT, 1);
    settle();
    for (int i = 0; i < 4; i++) pixel_q.insert(pixel_q.size(), 8'($urandom_range(255)));
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 46 : 0;
      recv_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 7 : 0;
      sent = 0;
      while (sent < 80) begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        write_reg(pse_pkg::REG_WIDTH, 16'(w));
        write_reg(pse_pkg::REG_HEIGHT, 16'(h));
        settle();
        queue_file(w, h);
        if (mode == 2 && sent == 0) begin
          // receiver holds off while the sender keeps offering words
          fork
            begin
              hold_on <= 1'b1;
              repeat (400) @(posedge clk);
              hold_on <= 1'b0;
            end
          join_none
          queue_file(w, h);
          sent += 4 * w * h;
        end
        settle();
        sent += 4 * w * h;
      end
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
